/* sv/sca_pkg.sv */
package sca_pkg;

  // Sizing of the heap and of the per-item fields.
  localparam int unsigned HEAP_PAGES_DEF = 64;
  localparam int unsigned CLASS_COUNT    = 7;
  localparam int unsigned PAGE_SHIFT     = 12;
  localparam int unsigned SLOT_SHIFT     = 4;
  localparam int unsigned SLOTS_PER_PAGE = 256;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned SIZE_W   = 9;
  localparam int unsigned PAGE_W   = 20;
  localparam int unsigned CLASS_W  = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LEFT_W   = 9;
  localparam int unsigned AVAIL_W  = 7;

  localparam logic [PAGE_W-1:0]  HEAP_TOP_RESET    = 20'd525308;
  localparam logic [AVAIL_W-1:0] PAGES_AVAIL_RESET = 7'd64;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_SIZE  = 2'd1,
    STATUS_NO_MEMORY = 2'd2
  } status_e;

  typedef enum logic {
    REG_HEAP_TOP    = 1'b0,
    REG_PAGES_AVAIL = 1'b1
  } reg_e;

  typedef struct packed {
    logic [PAGE_W-1:0]  heap_top_page;
    logic [AVAIL_W-1:0] pages_available;
  } cfg_t;

  // Classified request as it waits between the front and the back end.
  typedef struct packed {
    logic               is_free;
    logic               bad_size;
    logic [CLASS_W-1:0] size_class;
    logic               in_heap;
  } item_t;

  function automatic logic [CLASS_W-1:0] class_of(input logic [7:0] size);
    logic [CLASS_W-1:0] c;
    if (size <= 8'd16) c = 3'd0;
    else if (size <= 8'd32) c = 3'd1;
    else if (size <= 8'd64) c = 3'd2;
    else if (size <= 8'd96) c = 3'd3;
    else if (size <= 8'd128) c = 3'd4;
    else if (size <= 8'd192) c = 3'd5;
    else c = 3'd6;
    return c;
  endfunction

  function automatic logic [LEFT_W-1:0] class_bytes(input logic [CLASS_W-1:0] c);
    logic [LEFT_W-1:0] b;
    unique case (c)
      3'd0:    b = 9'd16;
      3'd1:    b = 9'd32;
      3'd2:    b = 9'd64;
      3'd3:    b = 9'd96;
      3'd4:    b = 9'd128;
      3'd5:    b = 9'd192;
      default: b = 9'd256;
    endcase
    return b;
  endfunction

  // Blocks that one 4 KiB page holds for each class.
  function automatic logic [LEFT_W-1:0] blocks_per_page(input logic [CLASS_W-1:0] c);
    logic [LEFT_W-1:0] n;
    unique case (c)
      3'd0:    n = 9'd256;
      3'd1:    n = 9'd128;
      3'd2:    n = 9'd64;
      3'd3:    n = 9'd42;
      3'd4:    n = 9'd32;
      3'd5:    n = 9'd21;
      default: n = 9'd16;
    endcase
    return n;
  endfunction

endpackage

/* sv/sca_req_if.sv */
interface sca_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [8:0]  request_size;
  logic [31:0] block_address;

  modport source (output valid, kind, request_size, block_address, input ready);
  modport sink (input valid, kind, request_size, block_address, output ready);
endinterface

/* sv/sca_rsp_if.sv */
interface sca_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_address;
  logic [2:0]  size_class;
  logic [1:0]  status;

  modport source (output valid, result_address, size_class, status, input ready);
  modport sink (input valid, result_address, size_class, status, output ready);
endinterface

/* sv/sca_ram.sv */
module sca_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/sca_front.sv */
module sca_front #(
  parameter int unsigned HEAP_PAGES = sca_pkg::HEAP_PAGES_DEF,
  localparam int unsigned SLOT_W = $clog2(HEAP_PAGES * sca_pkg::SLOTS_PER_PAGE)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [sca_pkg::PAGE_W-1:0]    cfg_base_page_i,
  sca_req_if.sink                       req,
  output logic                          q_valid_o,
  output sca_pkg::item_t                q_item_o,
  output logic [SLOT_W-1:0]             q_slot_o,
  input  logic                          q_pop_i
);

  localparam int unsigned PTR_W = $clog2(sca_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(sca_pkg::QUEUE_DEPTH + 1);

  logic [CNT_W-1:0] count_q, count_d;
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic             seen_q;
  logic [sca_pkg::PAGE_W-1:0] base_q;

  sca_pkg::item_t    item_q [sca_pkg::QUEUE_DEPTH];
  logic [SLOT_W-1:0] slot_q [sca_pkg::QUEUE_DEPTH];

  logic                        push;
  logic [sca_pkg::PAGE_W-1:0]  base;
  logic [sca_pkg::ADDR_W-1:0]  offset;
  sca_pkg::item_t              item_new;

  assign req.ready = (count_q != CNT_W'(sca_pkg::QUEUE_DEPTH));
  assign push      = req.valid && req.ready;

  // The heap base is latched with the first transfer; that transfer uses it directly.
  assign base   = seen_q ? base_q : cfg_base_page_i;
  assign offset = req.block_address - {base, {sca_pkg::PAGE_SHIFT{1'b0}}};

  always_comb begin
    item_new.is_free    = (req.kind == sca_pkg::KIND_FREE);
    item_new.bad_size   = req.request_size[8];
    item_new.size_class = req.request_size[8] ? '0 : sca_pkg::class_of(req.request_size[7:0]);
    item_new.in_heap    = (offset[sca_pkg::ADDR_W-1:sca_pkg::PAGE_SHIFT]
                           < sca_pkg::PAGE_W'(HEAP_PAGES));
  end

  always_comb begin
    case ({push, q_pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      seen_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
        seen_q   <= 1'b1;
      end
      if (q_pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      item_q[wr_ptr_q] <= item_new;
      slot_q[wr_ptr_q] <= offset[SLOT_W+sca_pkg::SLOT_SHIFT-1:sca_pkg::SLOT_SHIFT];
      if (!seen_q) begin
        base_q <= cfg_base_page_i;
      end
    end
  end

  assign q_valid_o = (count_q != '0);
  assign q_item_o  = item_q[rd_ptr_q];
  assign q_slot_o  = slot_q[rd_ptr_q];

endmodule

/* sv/sca_back.sv */
module sca_back #(
  parameter int unsigned HEAP_PAGES = sca_pkg::HEAP_PAGES_DEF,
  localparam int unsigned SLOT_W = $clog2(HEAP_PAGES * sca_pkg::SLOTS_PER_PAGE)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sca_pkg::cfg_t      cfg_i,
  input  logic               q_valid_i,
  input  sca_pkg::item_t     q_item_i,
  input  logic [SLOT_W-1:0]  q_slot_i,
  output logic               q_pop_o,
  sca_rsp_if.source          rsp
);

  localparam int unsigned PL_W  = $clog2(HEAP_PAGES + 1);
  localparam int unsigned NC    = sca_pkg::CLASS_COUNT;
  localparam int unsigned AW    = sca_pkg::ADDR_W;
  localparam int unsigned PW    = sca_pkg::PAGE_W;
  localparam int unsigned CW    = sca_pkg::CLASS_W;
  localparam int unsigned LW    = sca_pkg::LEFT_W;
  localparam int unsigned LINK_W = SLOT_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INIT,
    ST_POP
  } state_e;

  state_e          state_q, state_d;
  logic            init_q, init_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            head_valid_q [NC];
  logic            head_valid_d [NC];
  logic [SLOT_W-1:0] head_slot_q [NC];
  logic [SLOT_W-1:0] head_slot_d [NC];
  logic [AW-1:0]   fresh_addr_q [NC];
  logic [AW-1:0]   fresh_addr_d [NC];
  logic [LW-1:0]   fresh_left_q [NC];
  logic [LW-1:0]   fresh_left_d [NC];
  logic [PW-1:0]   next_page_q, next_page_d;
  logic [PW-1:0]   base_page_q, base_page_d;
  logic [PL_W-1:0] pages_left_q, pages_left_d;
  logic            out_valid_q, out_valid_d;
  logic [AW-1:0]   out_addr_q, out_addr_d;
  logic [CW-1:0]   out_class_q, out_class_d;
  logic [sca_pkg::STATUS_W-1:0] out_status_q, out_status_d;

  logic              can_emit;
  logic [CW-1:0]     c;
  logic [CW-1:0]     sel_cls;
  logic [LW-1:0]     bytes;
  logic [LW-1:0]     per_page;
  logic [PW-1:0]     new_page;
  logic [AW-1:0]     page_addr;
  logic              ram_we, ram_re;
  logic [LINK_W-1:0] ram_rdata;

  assign c         = q_item_i.size_class;
  assign can_emit  = !out_valid_q || rsp.ready;
  assign sel_cls   = (state_q == ST_INIT) ? cnt_q : c;
  assign bytes     = sca_pkg::class_bytes(sel_cls);
  assign per_page  = sca_pkg::blocks_per_page(sel_cls);
  assign new_page  = next_page_q - 1'b1;
  assign page_addr = {new_page, {sca_pkg::PAGE_SHIFT{1'b0}}};

  // Link memory: one entry per 16-byte slot, holding a valid bit and the next slot.
  sca_ram #(
    .WIDTH (LINK_W),
    .DEPTH (HEAP_PAGES * sca_pkg::SLOTS_PER_PAGE)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (q_slot_i),
    .wdata_i ({head_valid_q[c], head_slot_q[c]}),
    .re_i    (ram_re),
    .raddr_i (head_slot_q[c]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    init_d       = init_q;
    cnt_d        = cnt_q;
    head_valid_d = head_valid_q;
    head_slot_d  = head_slot_q;
    fresh_addr_d = fresh_addr_q;
    fresh_left_d = fresh_left_q;
    next_page_d  = next_page_q;
    base_page_d  = base_page_q;
    pages_left_d = pages_left_q;
    out_valid_d  = out_valid_q && !rsp.ready;
    out_addr_d   = out_addr_q;
    out_class_d  = out_class_q;
    out_status_d = out_status_q;
    q_pop_o      = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          if (!init_q) begin
            next_page_d  = cfg_i.heap_top_page;
            base_page_d  = cfg_i.heap_top_page - PW'(HEAP_PAGES);
            pages_left_d = (32'(cfg_i.pages_available) < HEAP_PAGES)
                           ? PL_W'(cfg_i.pages_available) : PL_W'(HEAP_PAGES);
            cnt_d        = '0;
            state_d      = ST_INIT;
          end else if (can_emit) begin
            out_valid_d  = 1'b1;
            out_addr_d   = '0;
            out_class_d  = c;
            out_status_d = sca_pkg::STATUS_OK;
            q_pop_o      = 1'b1;
            if (q_item_i.bad_size) begin
              out_class_d  = '0;
              out_status_d = sca_pkg::STATUS_BAD_SIZE;
            end else if (q_item_i.is_free) begin
              if (q_item_i.in_heap) begin
                ram_we          = 1'b1;
                head_valid_d[c] = 1'b1;
                head_slot_d[c]  = q_slot_i;
              end
            end else if (head_valid_q[c]) begin
              // Pop waits in ST_POP for the registered link of the head slot.
              out_valid_d = out_valid_q && !rsp.ready;
              q_pop_o     = 1'b0;
              ram_re      = 1'b1;
              state_d     = ST_POP;
            end else if (fresh_left_q[c] != '0) begin
              out_addr_d      = fresh_addr_q[c];
              fresh_addr_d[c] = fresh_addr_q[c] + AW'(bytes);
              fresh_left_d[c] = fresh_left_q[c] - 1'b1;
            end else if (pages_left_q != '0) begin
              next_page_d     = new_page;
              pages_left_d    = pages_left_q - 1'b1;
              out_addr_d      = page_addr;
              fresh_addr_d[c] = page_addr + AW'(bytes);
              fresh_left_d[c] = per_page - 1'b1;
            end else begin
              out_status_d = sca_pkg::STATUS_NO_MEMORY;
            end
          end
        end
      end
      ST_INIT: begin
        if (pages_left_q != '0) begin
          next_page_d         = new_page;
          pages_left_d        = pages_left_q - 1'b1;
          fresh_addr_d[cnt_q] = page_addr;
          fresh_left_d[cnt_q] = per_page;
        end
        if (cnt_q == CW'(NC - 1)) begin
          init_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_POP: begin
        if (can_emit) begin
          out_valid_d     = 1'b1;
          out_addr_d      = {base_page_q, {sca_pkg::PAGE_SHIFT{1'b0}}}
                            + AW'({head_slot_q[c], {sca_pkg::SLOT_SHIFT{1'b0}}});
          out_class_d     = c;
          out_status_d    = sca_pkg::STATUS_OK;
          head_valid_d[c] = ram_rdata[SLOT_W];
          head_slot_d[c]  = ram_rdata[SLOT_W-1:0];
          q_pop_o         = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      init_q       <= 1'b0;
      cnt_q        <= '0;
      head_valid_q <= '{default: 1'b0};
      head_slot_q  <= '{default: '0};
      fresh_left_q <= '{default: '0};
      next_page_q  <= '0;
      pages_left_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      init_q       <= init_d;
      cnt_q        <= cnt_d;
      head_valid_q <= head_valid_d;
      head_slot_q  <= head_slot_d;
      fresh_left_q <= fresh_left_d;
      next_page_q  <= next_page_d;
      pages_left_q <= pages_left_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fresh_addr_q <= fresh_addr_d;
    base_page_q  <= base_page_d;
    out_addr_q   <= out_addr_d;
    out_class_q  <= out_class_d;
    out_status_q <= out_status_d;
  end

  assign rsp.valid          = out_valid_q;
  assign rsp.result_address = out_addr_q;
  assign rsp.size_class     = out_class_q;
  assign rsp.status         = out_status_q;

endmodule

/* sv/size_class_block_allocator.sv */
// A request is registered into a two-entry queue, and the back end registers its result.
// Throughput: one request per cycle while the receiver keeps up; an allocation served from a
// free list holds the next request while it waits in ST_POP for the registered read port of
// the link memory. The first request after reset waits while the registers are latched and
// each of the seven size classes takes its first page while pages are left. Reset empties all
// free lists; the link memory is not cleared and needs no clearing pass.
module size_class_block_allocator #(
  parameter int unsigned HEAP_PAGES = sca_pkg::HEAP_PAGES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sca_req_if.sink     req,
  sca_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned SLOT_W = $clog2(HEAP_PAGES * sca_pkg::SLOTS_PER_PAGE);

  // Configuration registers. Writes land whenever the access phase completes; the back
  // end latches them only on the first request, so later writes leave the heap unchanged.
  sca_pkg::cfg_t cfg_q;
  logic          cfg_write;
  sca_pkg::reg_e reg_sel;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_sel   = sca_pkg::reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.heap_top_page   <= sca_pkg::HEAP_TOP_RESET;
      cfg_q.pages_available <= sca_pkg::PAGES_AVAIL_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        sca_pkg::REG_HEAP_TOP:    cfg_q.heap_top_page   <= pwdata[sca_pkg::PAGE_W-1:0];
        sca_pkg::REG_PAGES_AVAIL: cfg_q.pages_available <= pwdata[sca_pkg::AVAIL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      sca_pkg::REG_HEAP_TOP:    prdata = 32'(cfg_q.heap_top_page);
      sca_pkg::REG_PAGES_AVAIL: prdata = 32'(cfg_q.pages_available);
      default:                  prdata = '0;
    endcase
  end

  // The front end classifies each transfer (size class, bad size, heap slot of a freed
  // address) and queues it; the back end owns the free lists, fresh pages and heap cursor.
  logic                 q_valid;
  sca_pkg::item_t       q_item;
  logic [SLOT_W-1:0]    q_slot;
  logic                 q_pop;
  logic [sca_pkg::PAGE_W-1:0] cfg_base_page;

  assign cfg_base_page = cfg_q.heap_top_page - sca_pkg::PAGE_W'(HEAP_PAGES);

  sca_front #(
    .HEAP_PAGES (HEAP_PAGES)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_base_page_i (cfg_base_page),
    .req             (req),
    .q_valid_o       (q_valid),
    .q_item_o        (q_item),
    .q_slot_o        (q_slot),
    .q_pop_i         (q_pop)
  );

  sca_back #(
    .HEAP_PAGES (HEAP_PAGES)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_slot_i  (q_slot),
    .q_pop_o   (q_pop),
    .rsp       (rsp)
  );

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import sca_pkg::*;

  localparam int HEAP_PAGES  = HEAP_PAGES_DEF;
  localparam int PAGE_BYTES  = 4096;
  localparam int HEAP_BYTES  = HEAP_PAGES * PAGE_BYTES;
  localparam int SLOT_COUNT  = HEAP_PAGES * (PAGE_BYTES / 16);
  localparam int SLOT_W      = $clog2(SLOT_COUNT);
  localparam int PHASES      = 5;
  localparam int PHASE_ITEMS = 200;
  localparam int HOLD_CYCLES = 250;
  // Settle time after a drain, once every queued request has been classified and answered.
  localparam int SETTLE_CYCLES = 12;

  // One predicted answer of the allocator.
  typedef struct packed {
    logic [31:0] addr;
    logic [2:0]  cls;
    status_e     status;
  } grant_t;

  // A block that the allocator has handed out and that has not been freed yet.
  typedef struct packed {
    logic [31:0] addr;
    logic [2:0]  cls;
  } block_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sca_req_if req_ch ();
  sca_rsp_if rsp_ch ();

  size_class_block_allocator dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // The clock runs with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Bytes in one block of class c.
  function automatic int block_bytes(input int c);
    case (c)
      0:       return 16;
      1:       return 32;
      2:       return 64;
      3:       return 96;
      4:       return 128;
      5:       return 192;
      default: return 256;
    endcase
  endfunction

  // The smallest class whose block holds the requested size.
  function automatic logic [2:0] size_to_class(input logic [8:0] size);
    for (int c = 0; c < CLASS_COUNT - 1; c++) begin
      if (int'(size) <= block_bytes(c)) return 3'(c);
    end
    return 3'(CLASS_COUNT - 1);
  endfunction

  // The heap tracker mirrors the allocator's free lists, fresh pages and heap cursor.
  // Each accepted request is turned into the answer the allocator owes, and answers
  // leaving the block are checked against those in the order the requests came in.
  class heap_tracker;
    logic [19:0]       cfg_top;
    logic [6:0]        cfg_pages;
    bit                started;
    logic [19:0]       heap_page;
    logic [19:0]       base_page;
    int                pages_left;
    bit                head_valid [CLASS_COUNT];
    logic [SLOT_W-1:0] head_slot  [CLASS_COUNT];
    logic [31:0]       fresh_addr [CLASS_COUNT];
    int                fresh_left [CLASS_COUNT];
    logic [SLOT_W:0]   links      [SLOT_COUNT];
    grant_t            pending_grants [$];
    int                failures;

    function new();
      cfg_top    = HEAP_TOP_RESET;
      cfg_pages  = PAGES_AVAIL_RESET;
      started    = 1'b0;
      heap_page  = '0;
      base_page  = '0;
      pages_left = 0;
      failures   = 0;
      for (int c = 0; c < CLASS_COUNT; c++) begin
        head_valid[c] = 1'b0;
        head_slot[c]  = '0;
        fresh_addr[c] = '0;
        fresh_left[c] = 0;
      end
    endfunction

    function void write_setting(reg_e idx, logic [31:0] value);
      case (idx)
        REG_HEAP_TOP:    cfg_top = value[19:0];
        REG_PAGES_AVAIL: cfg_pages = value[6:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] heap_base();
      return {base_page, 12'h000};
    endfunction

    function int pending();
      return pending_grants.size();
    endfunction

    // The heap grows downward; each new page starts a fresh run of blocks for one class.
    function bit take_page(int c);
      if (pages_left == 0) return 1'b0;
      pages_left--;
      heap_page     = heap_page - 20'd1;
      fresh_addr[c] = {heap_page, 12'h000};
      fresh_left[c] = PAGE_BYTES / block_bytes(c);
      return 1'b1;
    endfunction

    function grant_t predict_request(kind_e kind, logic [8:0] size, logic [31:0] addr);
      grant_t            g;
      int                c;
      logic [SLOT_W-1:0] s;
      logic [SLOT_W:0]   link;
      logic [31:0]       offset;
      g.addr   = '0;
      g.cls    = '0;
      g.status = STATUS_OK;
      // The settings are latched only by the very first request, whatever it is.
      if (!started) begin
        heap_page  = cfg_top;
        base_page  = cfg_top - 20'(HEAP_PAGES);
        pages_left = (int'(cfg_pages) < HEAP_PAGES) ? int'(cfg_pages) : HEAP_PAGES;
        for (int i = 0; i < CLASS_COUNT; i++) void'(take_page(i));
        started = 1'b1;
      end
      if (size >= 9'd256) begin
        g.status = STATUS_BAD_SIZE;
      end else begin
        c     = int'(size_to_class(size));
        g.cls = 3'(c);
        if (kind == KIND_ALLOC) begin
          if (head_valid[c]) begin
            s             = head_slot[c];
            link          = links[s];
            g.addr        = heap_base() + (32'(s) << 4);
            head_valid[c] = link[SLOT_W];
            head_slot[c]  = link[SLOT_W-1:0];
          end else if (fresh_left[c] == 0 && !take_page(c)) begin
            g.status = STATUS_NO_MEMORY;
          end else begin
            g.addr        = fresh_addr[c];
            fresh_addr[c] = fresh_addr[c] + 32'(block_bytes(c));
            fresh_left[c]--;
          end
        end else begin
          // Addresses outside the heap are dropped; the low four bits never matter.
          offset = addr - heap_base();
          if (offset < 32'(HEAP_BYTES)) begin
            s             = SLOT_W'((offset >> 4) % SLOT_COUNT);
            links[s]      = {head_valid[c], head_slot[c]};
            head_valid[c] = 1'b1;
            head_slot[c]  = s;
          end
        end
      end
      pending_grants.push_back(g);
      return g;
    endfunction

    function void check_grant(logic [31:0] addr, logic [2:0] cls, logic [1:0] status);
      grant_t g;
      if (pending_grants.size() == 0) begin
        $display("%0t: unexpected result addr %h class %0d status %0d",
                 $time, addr, cls, status);
        failures++;
        return;
      end
      g = pending_grants.pop_front();
      if (addr !== g.addr) begin
        $display("%0t: result_address expected %h got %h", $time, g.addr, addr);
        failures++;
      end
      if (cls !== g.cls) begin
        $display("%0t: size_class expected %0d got %0d", $time, g.cls, cls);
        failures++;
      end
      if (status !== g.status) begin
        $display("%0t: status expected %0d got %0d", $time, g.status, status);
        failures++;
      end
    endfunction
  endclass

  heap_tracker book;
  block_t      live_q [$];
  logic [31:0] freed_q [$];
  bit          burst_mode = 1'b0;
  bit          hold_rsp = 1'b0;

  // Most idle gaps are short, a few are long, and burst stretches have none at all.
  function automatic int idle_len();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  // Offers one request and returns once it has been transferred. The valid stays high
  // afterward so that a following request can go out back to back; anything that pauses
  // the sender must lower it first.
  task automatic send_request(kind_e kind, logic [8:0] size, logic [31:0] addr);
    int     gap;
    grant_t g;
    gap = idle_len();
    @(negedge clk_i);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_ch.valid         = 1'b1;
    req_ch.kind          = kind;
    req_ch.request_size  = size;
    req_ch.block_address = addr;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    g = book.predict_request(kind, size, addr);
    // Blocks handed out become candidates for later frees.
    if (kind == KIND_ALLOC && g.status == STATUS_OK) live_q.push_back({g.addr, g.cls});
    if (kind == KIND_FREE) begin
      freed_q.push_back(addr);
      if (freed_q.size() > 64) void'(freed_q.pop_front());
    end
  endtask

  // Stops the sender and waits until every owed result has come back.
  task automatic drain_results();
    @(negedge clk_i);
    req_ch.valid = 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One APB write: a setup phase, then an access phase that completes on pready.
  task automatic write_setting(reg_e idx, logic [31:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    book.write_setting(idx, value);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // One random request. Allocations and frees of blocks that are really out dominate,
  // so that free lists build up and pages run dry; the rest is bad sizes, unaligned,
  // mismatched and double frees, and frees of arbitrary addresses.
  task automatic random_item(int alloc_pct);
    int          r;
    int          f;
    int          idx;
    int          lo;
    block_t      blk;
    logic [8:0]  size;
    logic [31:0] addr;
    r = $urandom_range(0, 99);
    if (r < alloc_pct) begin
      send_request(KIND_ALLOC, 9'($urandom_range(0, 255)), $urandom);
    end else if (r < alloc_pct + 4) begin
      send_request(KIND_ALLOC, 9'($urandom_range(256, 511)), $urandom);
    end else begin
      f = $urandom_range(0, 99);
      if (f < 70 && live_q.size() > 0) begin
        idx = $urandom_range(0, live_q.size() - 1);
        blk = live_q[idx];
        live_q.delete(idx);
        addr = blk.addr;
        if ($urandom_range(0, 9) == 0) addr[3:0] = 4'($urandom_range(1, 15));
        if ($urandom_range(0, 99) < 85) begin
          lo   = (blk.cls == 3'd0) ? 0 : block_bytes(int'(blk.cls) - 1) + 1;
          size = 9'($urandom_range(lo, block_bytes(int'(blk.cls))));
        end else begin
          size = 9'($urandom_range(0, 511));
        end
        send_request(KIND_FREE, size, addr);
      end else if (f < 80 && freed_q.size() > 0) begin
        addr = freed_q[$urandom_range(0, freed_q.size() - 1)];
        send_request(KIND_FREE, 9'($urandom_range(0, 255)), addr);
      end else if (f < 88) begin
        addr = book.heap_base() + 32'($urandom_range(0, HEAP_BYTES - 1));
        send_request(KIND_FREE, 9'($urandom_range(0, 255)), addr);
      end else begin
        send_request(KIND_FREE, 9'($urandom_range(0, 511)), $urandom);
      end
    end
  endtask

  // The receiver idles at random. When asked, it holds off for a long stretch of its
  // own so that the block's queue fills up and it stops taking requests.
  initial begin : rsp_driver
    int gap;
    forever begin
      @(negedge clk_i);
      if (hold_rsp) begin
        rsp_ch.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_rsp = 1'b0;
      end else begin
        gap = idle_len();
        if (gap == 0) begin
          rsp_ch.ready = 1'b1;
        end else begin
          rsp_ch.ready = 1'b0;
          repeat (gap - 1) @(negedge clk_i);
        end
      end
    end
  end

  // Every result transfer is checked against the oldest owed answer.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      book.check_grant(rsp_ch.result_address, rsp_ch.size_class, rsp_ch.status);
    end
  end

  initial begin : main
    int          phase;
    int          n;
    int          pct;
    int          pause_at;
    block_t      blk;
    logic [19:0] top_sel;
    book                 = new();
    req_ch.valid         = 1'b0;
    req_ch.kind          = KIND_ALLOC;
    req_ch.request_size  = '0;
    req_ch.block_address = '0;
    rsp_ch.ready         = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    rst_ni               = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Each register is first written with an extreme value before the settings that the first
    // request will latch. A small page budget lets the heap run dry within the run.
    write_setting(REG_HEAP_TOP, 32'hFFFFF);
    write_setting(REG_PAGES_AVAIL, 32'd0);
    case ($urandom_range(0, 3))
      0:       top_sel = HEAP_TOP_RESET;
      1:       top_sel = 20'd0;
      2:       top_sel = 20'd40;
      default: top_sel = 20'hFFFFF;
    endcase
    write_setting(REG_HEAP_TOP, 32'(top_sel));
    write_setting(REG_PAGES_AVAIL, 32'($urandom_range(8, 10)));

    // Directed part. The first request carries a bad size and still sets up the heap.
    send_request(KIND_ALLOC, 9'd511, 32'hFFFFFFFF);
    // Both sides of every class boundary, from zero up to the first bad size.
    send_request(KIND_ALLOC, 9'd0, 32'h0);
    send_request(KIND_ALLOC, 9'd16, 32'h0);
    send_request(KIND_ALLOC, 9'd17, 32'h0);
    send_request(KIND_ALLOC, 9'd32, 32'h0);
    send_request(KIND_ALLOC, 9'd33, 32'h0);
    send_request(KIND_ALLOC, 9'd64, 32'h0);
    send_request(KIND_ALLOC, 9'd65, 32'h0);
    send_request(KIND_ALLOC, 9'd96, 32'h0);
    send_request(KIND_ALLOC, 9'd97, 32'h0);
    send_request(KIND_ALLOC, 9'd128, 32'h0);
    send_request(KIND_ALLOC, 9'd129, 32'h0);
    send_request(KIND_ALLOC, 9'd192, 32'h0);
    send_request(KIND_ALLOC, 9'd193, 32'h0);
    send_request(KIND_ALLOC, 9'd255, 32'h0);
    send_request(KIND_ALLOC, 9'd256, 32'h0);
    // A freed block of the largest class comes straight back from its free list.
    blk = live_q.pop_back();
    send_request(KIND_FREE, 9'd200, blk.addr);
    send_request(KIND_ALLOC, 9'd255, 32'h0);
    // An unaligned free, then a double free of the same block; both pops return it.
    blk = live_q.pop_front();
    send_request(KIND_FREE, 9'd1, blk.addr | 32'hF);
    send_request(KIND_FREE, 9'd16, blk.addr);
    send_request(KIND_ALLOC, 9'd8, 32'h0);
    send_request(KIND_ALLOC, 9'd8, 32'h0);
    // Frees of two arbitrary addresses, then a free with a bad size that changes nothing.
    send_request(KIND_FREE, 9'd0, 32'hFFFFFFFF);
    send_request(KIND_FREE, 9'd255, 32'h00000000);
    blk = live_q.pop_front();
    send_request(KIND_FREE, 9'd400, blk.addr);

    // Random part in phases with a varying share of allocations. Register writes
    // between phases land after the heap was set up and must leave it alone.
    for (phase = 0; phase < PHASES; phase++) begin
      drain_results();
      case (phase)
        0: begin
          write_setting(REG_HEAP_TOP, 32'hFFFFF);
          write_setting(REG_PAGES_AVAIL, 32'd127);
        end
        1: begin
          write_setting(REG_HEAP_TOP, 32'd0);
          write_setting(REG_PAGES_AVAIL, 32'd0);
        end
        default: begin
          write_setting(REG_HEAP_TOP, $urandom);
          write_setting(REG_PAGES_AVAIL, 32'($urandom_range(0, 127)));
        end
      endcase
      case (phase)
        0:       pct = 55;
        1:       pct = 75;
        2:       pct = 45;
        3:       pct = 85;
        default: pct = 35;
      endcase
      // The long hold-off on the result side overlaps a stretch of requests.
      if (phase == 1) hold_rsp = 1'b1;
      pause_at = $urandom_range(20, PHASE_ITEMS - 20);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 50 == 0) burst_mode = ($urandom_range(0, 3) == 0);
        if (n == pause_at) drain_results();
        random_item(pct);
      end
    end
    burst_mode = 1'b0;

    drain_results();
    if (book.failures == 0 && book.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Safety net against a hang: far longer than the slowest correct run.
  initial begin : watchdog
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

/* filelist.f */
sv/sca_pkg.sv
sv/sca_req_if.sv
sv/sca_rsp_if.sv
sv/sca_ram.sv
sv/sca_front.sv
sv/sca_back.sv
sv/size_class_block_allocator.sv
tb/sv/tb_top.sv
